FILE: design/bls_pkg.sv
// Package of shared types and constants for the bounded LIFO stack with search.
`timescale 1ns / 1ps

package bls_pkg;

  // Widths of a stack word, a command code, the capacity and the fixed result fields.
  localparam int unsigned WordW  = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CapW   = 7;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;

  // Capacity register value after reset.
  localparam logic [CapW-1:0] CapReset = 7'd64;

  // Command codes carried by a request.
  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_e;

  // Sequencer states of the controller.
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // Result fields other than the data word.
  typedef struct packed {
    logic              status;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
    logic              empty;
    logic              full;
  } res_t;

endpackage

FILE: design/bls_mem.sv
// Single-port-write, single-port-read stack memory with a registered read.
`timescale 1ns / 1ps

module bls_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [bls_pkg::WordW-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [bls_pkg::WordW-1:0] rdata_o
);
  import bls_pkg::*;

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rdata_q;

  // Write port and registered read port; a read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bls_ctrl.sv
// Command sequencer: stack pointer, search walk and result registers.
`timescale 1ns / 1ps

module bls_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [bls_pkg::CmdW-1:0]          command_i,
  input  logic signed [bls_pkg::WordW-1:0]  value_i,
  input  logic [bls_pkg::CapW-1:0]          cap_i,
  output logic                              busy_o,
  output logic                              valid_o,
  output bls_pkg::res_t                     res_o,
  output logic signed [bls_pkg::WordW-1:0]  data_o,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic [bls_pkg::WordW-1:0]         mem_wdata_o,
  output logic [AW-1:0]                     mem_raddr_o,
  input  logic [bls_pkg::WordW-1:0]         mem_rdata_i
);
  import bls_pkg::*;

  // Common width for comparing the count against the capacity.
  localparam int unsigned XW = (CW > CapW) ? CW : CapW;
  // Width that holds both an index and the position field.
  localparam int unsigned PW = (AW > PosW) ? AW : PosW;

  state_e           state_q, state_d;
  logic [CW-1:0]    top_q, top_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [WordW-1:0] key_q, key_d;
  logic             valid_q, valid_d;
  logic             sel_rd_q, sel_rd_d;
  res_t             res_q, res_d;

  logic [XW-1:0] eff_cap;
  logic [XW-1:0] cap_x;
  logic [XW-1:0] top_nx;
  logic [CW-1:0] top_dec;
  logic [AW-1:0] idx_dec;
  logic [PW-1:0] pos_x;
  logic          accept;
  logic          match;

  // Effective capacity saturates at the built depth.
  assign cap_x   = XW'(cap_i);
  assign eff_cap = (cap_x < XW'(DEPTH)) ? cap_x : XW'(DEPTH);

  assign accept  = start_i && (state_q == ST_IDLE);
  assign top_dec = top_q - CW'(1);
  assign idx_dec = idx_q - AW'(1);
  assign match   = (mem_rdata_i == key_q);
  assign pos_x   = PW'(idx_q);
  assign top_nx  = XW'(top_d);

  // Next state, stack pointer, memory access and result fields.
  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    idx_d       = idx_q;
    key_d       = key_q;
    valid_d     = 1'b0;
    sel_rd_d    = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = top_q[AW-1:0];
    mem_wdata_o = value_i;
    mem_raddr_o = (top_q == '0) ? '0 : top_dec[AW-1:0];
    res_d       = res_q;
    res_d.status   = 1'b1;
    res_d.position = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          unique case (command_i)
            CMD_PUSH: begin
              if (XW'(top_q) < eff_cap) begin
                mem_we_o     = 1'b1;
                top_d        = top_q + CW'(1);
                res_d.status = 1'b0;
              end
            end
            CMD_POP: begin
              if (top_q != '0) begin
                top_d        = top_dec;
                sel_rd_d     = 1'b1;
                res_d.status = 1'b0;
              end
            end
            CMD_PEEK: begin
              if (top_q != '0) begin
                sel_rd_d     = 1'b1;
                res_d.status = 1'b0;
              end
            end
            CMD_CLEAR: begin
              top_d        = '0;
              res_d.status = 1'b0;
            end
            CMD_SEARCH: begin
              // The read issued now returns the top entry for the first compare.
              if (top_q != '0) begin
                valid_d = 1'b0;
                idx_d   = top_dec[AW-1:0];
                key_d   = value_i;
                state_d = ST_SEARCH;
              end
            end
            default: begin
              res_d.status = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // One entry is compared per cycle while the next one below is read.
        mem_raddr_o = (idx_q == '0) ? '0 : idx_dec;
        if (match) begin
          valid_d        = 1'b1;
          res_d.status   = 1'b0;
          res_d.position = pos_x[PosW-1:0];
          state_d        = ST_IDLE;
        end else if (idx_q == '0) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_dec;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.count = top_nx[CountW-1:0];
    res_d.empty = (top_d == '0);
    res_d.full  = (top_nx >= eff_cap);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      top_q    <= '0;
      valid_q  <= 1'b0;
      sel_rd_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      valid_q  <= valid_d;
      sel_rd_q <= sel_rd_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign busy_o  = (state_q == ST_SEARCH);
  assign valid_o = valid_q;
  assign res_o   = res_q;
  // The memory read register holds the popped or peeked word in the result cycle.
  assign data_o  = sel_rd_q ? mem_rdata_i : '0;

endmodule

FILE: design/bounded_lifo_stack_with_search_unit.sv
// Top level of the bounded LIFO stack with search: capacity register and instances.
//
//   Channel   Signals                                     Direction  Handshake
//   request   start_i, command_i, value_i                 in         start_i && !busy_o
//   result    valid_o, status_o, data_o, position_o,      out        valid_o, one cycle
//             count_o, empty_res_o, full_res_o
//   config    cfg_we_i, cfg_wdata_i                       in         cfg_we_i
//
// For push, pop, peek, clear and unknown commands the result appears in the cycle
// after the request and a new request may be taken then.
// Search compares one entry per cycle through the memory read port, top down,
// and keeps busy_o high until a match is found or the bottom entry is compared;
// a search of an empty stack answers without raising busy_o.
// Reset clears the count and sets the capacity to 64; memory words are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps

module bounded_lifo_stack_with_search_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [bls_pkg::CmdW-1:0]          command_i,
  input  logic signed [bls_pkg::WordW-1:0]  value_i,
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CapW-1:0]          cfg_wdata_i,
  output logic                              valid_o,
  output logic                              status_o,
  output logic signed [bls_pkg::WordW-1:0]  data_o,
  output logic [bls_pkg::PosW-1:0]          position_o,
  output logic [bls_pkg::CountW-1:0]        count_o,
  output logic                              empty_res_o,
  output logic                              full_res_o
);
  import bls_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CapW-1:0]  cap_q;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [WordW-1:0] mem_rdata;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  bls_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .command_i   (command_i),
    .value_i     (value_i),
    .cap_i       (cap_q),
    .busy_o      (busy_o),
    .valid_o     (valid_o),
    .res_o       (res),
    .data_o      (data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bls_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result fields.
  assign status_o    = res.status;
  assign position_o  = res.position;
  assign count_o     = res.count;
  assign empty_res_o = res.empty;
  assign full_res_o  = res.full;

endmodule

FILE: design/bls_chk.sv
// Port-level checker for the stack unit and its bind statement.
`timescale 1ns / 1ps

module bls_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic [bls_pkg::CmdW-1:0]          command_i,
  input logic signed [bls_pkg::WordW-1:0]  value_i,
  input logic                              cfg_we_i,
  input logic [bls_pkg::CapW-1:0]          cfg_wdata_i,
  input logic                              valid_o,
  input logic                              status_o,
  input logic signed [bls_pkg::WordW-1:0]  data_o,
  input logic [bls_pkg::PosW-1:0]          position_o,
  input logic [bls_pkg::CountW-1:0]        count_o,
  input logic                              empty_res_o,
  input logic                              full_res_o
);
  import bls_pkg::*;

  // A request other than search gives its result in the next cycle.
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (command_i != CMD_SEARCH) |=> valid_o)
    else $error("no result after a single-cycle request");

  // A search request either answers at once or starts the walk.
  a_search_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (command_i == CMD_SEARCH) |=> valid_o || busy_o)
    else $error("search request neither answered nor started");

  // The end of a search walk always delivers its result.
  a_search_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o)
    else $error("search finished without a result");

  // A result is never shown while a search is still running.
  a_no_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // Returned data only comes with a successful pop or peek.
  a_data_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (data_o != '0) |-> !status_o && (position_o == '0))
    else $error("data word returned on a failing or search result");

endmodule

bind bounded_lifo_stack_with_search_unit bls_chk u_bls_chk (.*);
